[rtl/wsf_pkg.sv]
// Types and constants shared by the weight sample filter.
package wsf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MED,
        S_DLOAD,
        S_DRUN,
        S_FIN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_AVG     = 2'd1,
        MODE_IIR     = 2'd2,
        MODE_MED_IIR = 2'd3
    } t_mode;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_STRENGTH = 1'b1;

    localparam int MODE_W      = 2;
    localparam int STRENGTH_W  = 5;
    localparam int COUNT_W     = 32;

    localparam int AVG_MIN_WINDOW = 2;
    localparam int IIR_MIN_SHIFT  = 1;
    localparam int IIR_MAX_SHIFT  = 8;
    localparam int MED_TAPS       = 3;

endpackage

[rtl/weight_sample_filter_core.sv]
// Load-cell sample filter: pass-through, moving average, IIR and median-of-three IIR.
//
// One sample request is worked on at a time; o_in_ready is high only while the
// sequencer is idle. A request in pass-through mode, with an invalid mode/strength
// pair, as the IIR seeding sample or as a median warm-up sample goes straight to the
// emit step, which registers its result. A moving-average request passes through
// the window update, divider load, divider run, finish and emit steps; an IIR request
// skips the window update and a median IIR request has the median step in its place.
// The divider run uses the shared restoring divider, retiring one quotient bit per
// cycle of a quotient NUM_W = SAMPLE_BITS + clog2(MAX_WINDOW + 1) + 1 bits wide (30
// by default); it serves the moving-average sum / fill division and the IIR delta /
// 2^strength step, with round to nearest and ties away from zero. The window ring is a
// single-port memory read in the cycle before its update. A restart request clears the
// filter state in the cycle it is accepted and gives no result. A configuration write
// also clears the state; writes are expected only while the block is idle. A
// finished result sits in the output register until taken, and the next request
// may be accepted meanwhile; the sequencer only waits in its last step if the
// previous result has still not been taken. There is no clearing pass: window
// ring entries are read only after being written since the last clear.
module weight_sample_filter_core
    import wsf_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [STRENGTH_W-1:0]         i_cfg_data,
    // sample requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_value,
    output logic                          o_ready_flag,
    output logic                          o_config_error,
    output logic [COUNT_W-1:0]            o_accepted_total
);

    localparam int HEAD_W = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + FILL_W;
    localparam int CMP_W  = (FILL_W > STRENGTH_W) ? FILL_W : STRENGTH_W;
    localparam int DEN_W  = (FILL_W > IIR_MAX_SHIFT + 1) ? FILL_W : IIR_MAX_SHIFT + 1;
    localparam int NUM_W  = SUM_W + 1;
    localparam int RES_W  = NUM_W + 2;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic signed [RES_W-1:0] SAT_HI =
        RES_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
    localparam logic signed [RES_W-1:0] SAT_LO =
        RES_W'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

    // ---------------------------------------------------------------- state
    t_state                        r_state, n_state;
    t_mode                         r_mode, n_mode;
    logic [STRENGTH_W-1:0]         r_strength, n_strength;

    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [HEAD_W-1:0]             r_head, n_head;
    logic [FILL_W-1:0]             r_fill, n_fill;
    logic [1:0]                    r_mhead, n_mhead;
    logic [1:0]                    r_mfill, n_mfill;
    logic signed [SAMPLE_BITS-1:0] r_held, n_held;
    logic                          r_rdy, n_rdy;
    logic [COUNT_W-1:0]            r_count, n_count;

    // per-request working registers
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic                          r_seed, n_seed;
    logic                          r_err, n_err;
    logic                          r_base_en, n_base_en;
    logic signed [SUM_W-1:0]       r_num, n_num;
    logic [DEN_W-1:0]              r_den, n_den;
    logic [DEN_W-1:0]              r_rem, n_rem;
    logic [NUM_W-1:0]              r_quo, n_quo;
    logic                          r_neg, n_neg;
    logic [CNT_W-1:0]              r_cnt, n_cnt;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value, n_out_value;
    logic                          r_out_ready, n_out_ready;
    logic                          r_out_err, n_out_err;
    logic [COUNT_W-1:0]            r_out_total, n_out_total;

    // stores
    logic signed [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_med [MED_TAPS];
    logic                          ring_we;
    logic                          med_we;

    // combinational helpers
    logic                          cfg_ok;
    logic                          clear;
    logic                          win_full;
    logic signed [SUM_W-1:0]       drop;
    logic [1:0]                    mfill_inc;
    logic signed [SAMPLE_BITS-1:0] med_lo, med_hi, med_mid, med_val;
    logic [SUM_W-1:0]              mag;
    logic [DEN_W:0]                trial;
    logic                          qbit;
    logic signed [RES_W-1:0]       q_s, adj, base, total;

    // ------------------------------------------------ configuration check
    always_comb begin
        cfg_ok = 1'b0;
        unique case (r_mode) inside
            MODE_PASS: cfg_ok = 1'b1;
            MODE_AVG: cfg_ok = (CMP_W'(r_strength) >= CMP_W'(AVG_MIN_WINDOW)) &&
                               (CMP_W'(r_strength) <= CMP_W'(MAX_WINDOW));
            MODE_IIR, MODE_MED_IIR:
                cfg_ok = (r_strength >= STRENGTH_W'(IIR_MIN_SHIFT)) &&
                         (r_strength <= STRENGTH_W'(IIR_MAX_SHIFT));
        endcase
    end

    // median of the three stored samples
    always_comb begin
        med_lo  = (r_med[0] < r_med[1]) ? r_med[0] : r_med[1];
        med_hi  = (r_med[0] < r_med[1]) ? r_med[1] : r_med[0];
        med_mid = (med_hi < r_med[2]) ? med_hi : r_med[2];
        med_val = (med_lo > med_mid) ? med_lo : med_mid;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // ------------------------------------------------ sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_strength  = r_strength;
        n_sum       = r_sum;
        n_head      = r_head;
        n_fill      = r_fill;
        n_mhead     = r_mhead;
        n_mfill     = r_mfill;
        n_held      = r_held;
        n_rdy       = r_rdy;
        n_count     = r_count;
        n_x         = r_x;
        n_seed      = r_seed;
        n_err       = r_err;
        n_base_en   = r_base_en;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_ready = r_out_ready;
        n_out_err   = r_out_err;
        n_out_total = r_out_total;
        ring_we     = 1'b0;
        med_we      = 1'b0;
        clear       = 1'b0;
        win_full    = 1'b0;
        drop        = '0;
        mfill_inc   = r_mfill;
        mag         = '0;
        trial       = '0;
        qbit        = 1'b0;
        q_s         = '0;
        adj         = '0;
        base        = '0;
        total       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_RESTART) begin
                        clear = 1'b1;
                    end else begin
                        n_x    = i_raw_sample;
                        n_err  = !cfg_ok;
                        n_seed = (r_count == '0);
                        if (!cfg_ok) begin
                            n_state = S_EMIT;
                        end else begin
                            n_count = r_count + COUNT_W'(1);
                            unique case (r_mode)
                                MODE_PASS: begin
                                    n_held  = i_raw_sample;
                                    n_rdy   = 1'b1;
                                    n_state = S_EMIT;
                                end
                                MODE_AVG: begin
                                    n_state = S_AVG;
                                end
                                MODE_IIR: begin
                                    n_rdy = 1'b1;
                                    if (r_count == '0) begin
                                        n_held  = i_raw_sample;
                                        n_state = S_EMIT;
                                    end else begin
                                        n_num     = SUM_W'(i_raw_sample) - SUM_W'(r_held);
                                        n_den     = DEN_W'(1) << r_strength;
                                        n_base_en = 1'b1;
                                        n_state   = S_DLOAD;
                                    end
                                end
                                MODE_MED_IIR: begin
                                    med_we  = 1'b1;
                                    n_mhead = (r_mhead == 2'(MED_TAPS - 1)) ? 2'd0
                                                                            : r_mhead + 2'd1;
                                    if (r_mfill != 2'(MED_TAPS)) begin
                                        mfill_inc = r_mfill + 2'd1;
                                    end
                                    n_mfill = mfill_inc;
                                    if (mfill_inc != 2'(MED_TAPS)) begin
                                        // warm-up: hold, seeded by the first sample
                                        n_rdy = 1'b0;
                                        if (r_count == '0) begin
                                            n_held = i_raw_sample;
                                        end
                                        n_state = S_EMIT;
                                    end else begin
                                        n_rdy   = 1'b1;
                                        n_state = S_MED;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end

            S_AVG: begin
                // r_rd_data holds the entry about to be overwritten
                win_full = (CMP_W'(r_fill) == CMP_W'(r_strength));
                if (win_full) begin
                    drop = SUM_W'(r_rd_data);
                end else begin
                    n_fill = r_fill + FILL_W'(1);
                end
                ring_we   = 1'b1;
                n_sum     = r_sum - drop + SUM_W'(r_x);
                n_head    = (CMP_W'(r_head) + CMP_W'(1) == CMP_W'(r_strength)) ? '0
                                                                             : r_head + HEAD_W'(1);
                n_rdy     = (CMP_W'(n_fill) == CMP_W'(r_strength));
                n_num     = n_sum;
                n_den     = DEN_W'(n_fill);
                n_base_en = 1'b0;
                n_state   = S_DLOAD;
            end

            S_MED: begin
                if (r_seed) begin
                    n_held  = med_val;
                    n_state = S_EMIT;
                end else begin
                    n_num     = SUM_W'(med_val) - SUM_W'(r_held);
                    n_den     = DEN_W'(1) << r_strength;
                    n_base_en = 1'b1;
                    n_state   = S_DLOAD;
                end
            end

            S_DLOAD: begin
                // dividend is |num| + den/2 for round to nearest
                n_neg = r_num[SUM_W-1];
                mag   = r_num[SUM_W-1] ? SUM_W'(-r_num) : SUM_W'(r_num);
                n_quo = NUM_W'(mag) + NUM_W'(r_den >> 1);
                n_rem = '0;
                n_cnt = CNT_W'(NUM_W);
                n_state = S_DRUN;
            end

            S_DRUN: begin
                trial = {r_rem, r_quo[NUM_W-1]};
                if (trial >= {1'b0, r_den}) begin
                    n_rem = DEN_W'(trial - {1'b0, r_den});
                    qbit  = 1'b1;
                end else begin
                    n_rem = trial[DEN_W-1:0];
                end
                n_quo = {r_quo[NUM_W-2:0], qbit};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                q_s = RES_W'({2'b00, r_quo});
                adj = r_neg ? -q_s : q_s;
                if (r_base_en) begin
                    base = RES_W'(r_held);
                end
                total = base + adj;
                if (total > SAT_HI) begin
                    n_held = SAMPLE_BITS'(SAT_HI);
                end else if (total < SAT_LO) begin
                    n_held = SAMPLE_BITS'(SAT_LO);
                end else begin
                    n_held = SAMPLE_BITS'(total);
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_held;
                    n_out_ready = r_err ? 1'b0 : r_rdy;
                    n_out_err   = r_err;
                    n_out_total = r_count;
                    n_state     = S_IDLE;
                end
            end
        endcase

        if (i_cfg_we) begin
            clear = 1'b1;
            unique case (i_cfg_index)
                REG_MODE:     n_mode     = t_mode'(i_cfg_data[MODE_W-1:0]);
                REG_STRENGTH: n_strength = i_cfg_data;
            endcase
        end

        if (clear) begin
            n_sum   = '0;
            n_head  = '0;
            n_fill  = '0;
            n_mhead = '0;
            n_mfill = '0;
            n_held  = '0;
            n_rdy   = 1'b0;
            n_count = '0;
        end
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PASS;
            r_strength  <= STRENGTH_W'(1);
            r_sum       <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_mhead     <= '0;
            r_mfill     <= '0;
            r_held      <= '0;
            r_rdy       <= 1'b0;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_strength  <= n_strength;
            r_sum       <= n_sum;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_mhead     <= n_mhead;
            r_mfill     <= n_mfill;
            r_held      <= n_held;
            r_rdy       <= n_rdy;
            r_count     <= n_count;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_seed      <= n_seed;
        r_err       <= n_err;
        r_base_en   <= n_base_en;
        r_num       <= n_num;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_neg       <= n_neg;
        r_out_value <= n_out_value;
        r_out_ready <= n_out_ready;
        r_out_err   <= n_out_err;
        r_out_total <= n_out_total;
    end

    // window ring: one write, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_head] <= r_x;
        end
        r_rd_data <= r_ring[r_head];
    end

    // median taps
    always_ff @(posedge i_clk) begin
        if (med_we) begin
            r_med[r_mhead] <= i_raw_sample;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_ready_flag     = r_out_ready;
    assign o_config_error   = r_out_err;
    assign o_accepted_total = r_out_total;

    // ------------------------------------------------ assertions
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_AVG && cfg_ok) |-> (CMP_W'(r_fill) <= CMP_W'(r_strength)))
        else $error("window fill beyond configured length");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_opcode == OP_RESTART)
        |=> (r_count == '0 && r_fill == '0 && r_mfill == '0))
        else $error("restart request did not clear filter state");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRUN) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_mhead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mhead != 2'(MED_TAPS)) && (r_mfill <= 2'(MED_TAPS)))
        else $error("median ring pointer out of range");

endmodule
